### src/qtu_pkg.sv
// qtu_pkg: shared constants for the q-table update engine
// register indexes, configuration reset values and default sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qtu_pkg;

    // default sizes, handed to the top-level parameters
    localparam int DEF_MAX_STATES  = 16;
    localparam int DEF_MAX_ACTIONS = 32;
    localparam int DEF_VALUE_WIDTH = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ACTIONS   = 2'd2;

    // configuration reset values
    localparam logic [15:0] LR_RESET   = 16'd6554;
    localparam logic [15:0] DISC_RESET = 16'd58982;
    localparam logic [5:0]  NACT_RESET = 6'd22;

    // payload widths fixed by the interface
    localparam int STATE_W  = 4;
    localparam int ACTION_W = 5;
    localparam int FIX_W    = 16;
    localparam int NACT_W   = 6;

endpackage

`default_nettype wire

### src/q_table_update.sv
// q_table_update: tabular q-learning update engine, top level
// uses qtu_pkg, qtu_value_mem, qtu_update_alu
//
//  channel   signals                                    transaction
//  -------   -----------------------------------------  ----------------------------
//  command   start, busy, state, action, reward,         start high while busy low
//            next_state
//  result    done, new_value, best_next_value            done high, one cycle
//  config    cfg_we, cfg_index, cfg_data                 cfg_we high
//
// a transaction scans a row of n entries, n the clamped action count:
// the row scan reads one table entry per cycle through the single read port,
// then one read for the updated entry and the update arithmetic in qtu_update_alu.
// done comes from the last alu stage, then busy falls; the receiver cannot stall done.
// after reset a clearing pass writes zero to all MAX_STATES * MAX_ACTIONS entries
// (512 by default) with busy held high; config writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module q_table_update #(
    parameter int MAX_STATES  = qtu_pkg::DEF_MAX_STATES,
    parameter int MAX_ACTIONS = qtu_pkg::DEF_MAX_ACTIONS,
    parameter int VALUE_WIDTH = qtu_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [qtu_pkg::STATE_W-1:0]         state,
    input  wire logic [qtu_pkg::ACTION_W-1:0]        action,
    input  wire logic signed [qtu_pkg::FIX_W-1:0]    reward,
    input  wire logic [qtu_pkg::STATE_W-1:0]         next_state,
    output logic                                     done,
    output logic signed [qtu_pkg::FIX_W-1:0]         new_value,
    output logic signed [qtu_pkg::FIX_W-1:0]         best_next_value,
    input  wire logic                                cfg_we,
    input  wire logic [qtu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [qtu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import qtu_pkg::*;

    localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (MAX_STATES > 2) ? $clog2(MAX_STATES) : 1;
    localparam int CAW   = (MAX_ACTIONS > 2) ? $clog2(MAX_ACTIONS) : 1;
    localparam int CW    = $clog2(MAX_ACTIONS + 1);
    localparam int NW    = (CW > NACT_W) ? CW : NACT_W;
    localparam int MW    = 13;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_QRD   = 3'd3;
    localparam logic [2:0] ST_QWAIT = 3'd4;
    localparam logic [2:0] ST_ARITH = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [AW-1:0]                 clr_reg;
    logic [CW-1:0]                 idx_reg;
    logic [CW-1:0]                 n_reg;
    logic [AW-1:0]                 base_reg;
    logic [AW-1:0]                 slot_reg;
    logic signed [FIX_W-1:0]       reward_reg;
    logic                          scan_vld_reg;
    logic                          first_reg;
    logic signed [VALUE_WIDTH-1:0] best_reg;

    logic [15:0]                   lr_reg;
    logic [15:0]                   disc_reg;
    logic [NACT_W-1:0]             nact_reg;

    logic                          accept;
    logic [MW-1:0]                 row_red, col_red;
    logic [SW-1:0]                 row_idx, nrow_idx;
    logic [MW-1:0]                 nrow_red;
    logic [CAW-1:0]                col_idx;
    logic [NW-1:0]                 nact_w;
    logic [CW-1:0]                 n_eff;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [VALUE_WIDTH-1:0]        mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic [VALUE_WIDTH-1:0]        mem_rdata;
    logic signed [VALUE_WIDTH-1:0] rd_val;

    logic                          alu_go;
    logic                          alu_valid;
    logic signed [VALUE_WIDTH-1:0] alu_value;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign rd_val = $signed(mem_rdata);

    // row and column indexes reduced modulo the table size by compare and subtract
    always_comb
    begin
        row_red  = MW'(state);
        nrow_red = MW'(next_state);
        col_red  = MW'(action);
        for (int k = STATE_W - 1; k >= 0; k--)
        begin
            if (row_red >= MW'(MAX_STATES << k))
            begin
                row_red = row_red - MW'(MAX_STATES << k);
            end
            if (nrow_red >= MW'(MAX_STATES << k))
            begin
                nrow_red = nrow_red - MW'(MAX_STATES << k);
            end
        end
        for (int k = ACTION_W - 1; k >= 0; k--)
        begin
            if (col_red >= MW'(MAX_ACTIONS << k))
            begin
                col_red = col_red - MW'(MAX_ACTIONS << k);
            end
        end
        row_idx  = row_red[SW-1:0];
        nrow_idx = nrow_red[SW-1:0];
        col_idx  = col_red[CAW-1:0];
    end

    // columns scanned: at least one, at most the row length
    always_comb
    begin
        nact_w = NW'(nact_reg);
        if (nact_w == '0)
        begin
            n_eff = CW'(1);
        end
        else if (nact_w > NW'(MAX_ACTIONS))
        begin
            n_eff = CW'(MAX_ACTIONS);
        end
        else
        begin
            n_eff = nact_w[CW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == n_reg - CW'(1))
                begin
                    state_next = ST_QRD;
                end
            end
            ST_QRD:
            begin
                state_next = ST_QWAIT;
            end
            ST_QWAIT:
            begin
                state_next = ST_ARITH;
            end
            ST_ARITH:
            begin
                if (alu_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            idx_reg      <= '0;
            scan_vld_reg <= 1'b0;
            first_reg    <= 1'b0;
            lr_reg       <= LR_RESET;
            disc_reg     <= DISC_RESET;
            nact_reg     <= NACT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            scan_vld_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (accept)
            begin
                idx_reg   <= '0;
                first_reg <= 1'b1;
            end
            else
            begin
                if (state_reg == ST_SCAN)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (scan_vld_reg)
                begin
                    first_reg <= 1'b0;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_SIZE:     lr_reg   <= cfg_data;
                    REG_DISCOUNT:      disc_reg <= cfg_data;
                    REG_NUM_ACTIONS:   nact_reg <= cfg_data[NACT_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg      <= n_eff;
            base_reg   <= AW'(nrow_idx) * AW'(MAX_ACTIONS);
            slot_reg   <= AW'(row_idx) * AW'(MAX_ACTIONS) + AW'(col_idx);
            reward_reg <= reward;
        end
        // running maximum over the scanned entries as they return
        if (scan_vld_reg && (first_reg || (rd_val > best_reg)))
        begin
            best_reg <= rd_val;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_SCAN:  mem_raddr = base_reg + AW'(idx_reg);
            ST_QRD:   mem_raddr = slot_reg;
            default:  mem_raddr = base_reg;
        endcase
    end

    assign mem_we    = (state_reg == ST_CLEAR) || alu_valid;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : slot_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : alu_value;
    assign alu_go    = (state_reg == ST_QWAIT);

    qtu_value_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .VW    (VALUE_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    qtu_update_alu #(
        .VW (VALUE_WIDTH)
    ) u_alu (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (alu_go),
        .q             (rd_val),
        .best          (best_reg),
        .reward        (reward_reg),
        .step_size     (lr_reg),
        .discount      (disc_reg),
        .valid         (alu_valid),
        .value         (alu_value)
    );

    assign done            = alu_valid;
    assign new_value       = FIX_W'(alu_value);
    assign best_next_value = FIX_W'(best_reg);

endmodule

`default_nettype wire

### src/qtu_value_mem.sv
// qtu_value_mem: value table storage, one write and one read port
// read data registered; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module qtu_value_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int VW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [VW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [VW-1:0] rdata
);

    logic [VW-1:0] mem [DEPTH];

    // read returns the old entry when the same address is written in the same cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/qtu_update_alu.sv
// qtu_update_alu: four-stage pipeline for q + alpha*(r + gamma*max - q)
// rounding is add-half then arithmetic shift; only the final sum saturates
// uses qtu_pkg
`timescale 1ns / 1ps
`default_nettype none

module qtu_update_alu #(
    parameter int VW = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           go,
    input  wire logic signed [VW-1:0]           q,
    input  wire logic signed [VW-1:0]           best,
    input  wire logic signed [qtu_pkg::FIX_W-1:0] reward,
    input  wire logic [15:0]                    step_size,
    input  wire logic [15:0]                    discount,
    output logic                                valid,
    output logic signed [VW-1:0]                value
);

    import qtu_pkg::*;

    localparam int DW  = ((VW > FIX_W) ? VW : FIX_W) + 3;
    localparam int P1W = VW + 17;
    localparam int P2W = DW + 17;
    localparam int SW  = DW + 2;

    localparam logic signed [SW-1:0] VMAX = {{(SW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = ~VMAX;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [P1W-1:0]   prod1_reg;
    logic signed [VW-1:0]    q1_reg, q2_reg, q3_reg;
    logic signed [FIX_W-1:0] rw1_reg;
    logic signed [DW-1:0]    d_reg;
    logic signed [P2W-1:0]   prod2_reg;
    logic signed [VW-1:0]    value_reg;

    logic signed [P1W-1:0]   rnd1;
    logic signed [P1W-17:0]  t_val;
    logic signed [DW-1:0]    d_next;
    logic signed [P2W-1:0]   rnd2;
    logic signed [P2W-17:0]  delta;
    logic signed [SW-1:0]    sum;
    logic signed [VW-1:0]    value_next;

    always_comb
    begin
        rnd1   = prod1_reg + P1W'(32768);
        t_val  = rnd1[P1W-1:16];
        d_next = DW'(rw1_reg) + DW'(t_val) - DW'(q1_reg);

        rnd2  = prod2_reg + P2W'(32768);
        delta = rnd2[P2W-1:16];
        sum   = SW'(q3_reg) + SW'(delta);
        if (sum > VMAX)
        begin
            value_next = VMAX[VW-1:0];
        end
        else if (sum < VMIN)
        begin
            value_next = VMIN[VW-1:0];
        end
        else
        begin
            value_next = sum[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // gamma * max
        prod1_reg <= P1W'($signed({1'b0, discount})) * P1W'(best);
        q1_reg    <= q;
        rw1_reg   <= reward;
        // temporal difference
        d_reg     <= d_next;
        q2_reg    <= q1_reg;
        // alpha * difference
        prod2_reg <= P2W'($signed({1'b0, step_size})) * P2W'(d_reg);
        q3_reg    <= q2_reg;
        value_reg <= value_next;
    end

    assign valid = v4_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

### src/qtu_checker.sv
// qtu_checker: port-level assertions for q_table_update, bound to the top level
// watches the command and result handshakes only; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module qtu_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // an accepted transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // a result only appears while a transaction is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // the strobe lasts a single cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // the block is free for the next command right after the result
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after the result");

endmodule

bind q_table_update qtu_checker u_qtu_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
